// ----- hdl/lstk_pkg.sv -----
package lstk_pkg;

  localparam logic [1:0] K_PUSH   = 2'd0;
  localparam logic [1:0] K_POP    = 2'd1;
  localparam logic [1:0] K_PEEK   = 2'd2;
  localparam logic [1:0] K_SEARCH = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [6:0] MAX_RES = 7'd64;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [5:0]         idx;
    logic [6:0]         count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic accept;       // input transfer taken this cycle
    logic emit_read;    // move read data into the output register
    logic scan_en;      // let the search scan advance
    logic scan_finish;  // write the closing search result
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
    logic scan_idle;
  } sts_t;

endpackage

// ----- hdl/lstk_ctrl.sv -----
module lstk_ctrl
  import lstk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic [1:0] kind,
  input  sts_t       sts,
  output logic       s_tready,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE) && sts.out_free;

  always_comb begin
    cmd             = '0;
    cmd.accept      = s_tvalid && s_tready;
    cmd.emit_read   = (state == S_READ) && sts.out_free;
    cmd.scan_en     = (state == S_SCAN);
    cmd.scan_finish = (state == S_SCAN) && sts.scan_idle && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.accept && !sts.empty) begin
            unique case (kind) inside
              K_POP, K_PEEK: state <= S_READ;
              K_SEARCH:      state <= S_SCAN;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          if (cmd.emit_read) state <= S_IDLE;
        end
        S_SCAN: begin
          if (cmd.scan_finish) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/lstk_dp.sv -----
module lstk_dp
  import lstk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [1:0]         kind,
  input  logic signed [31:0] data_in,
  input  logic               m_tready,
  output sts_t               sts,
  output logic               out_valid,
  output res_t               out
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;

  logic [CW-1:0]      fill;
  logic [CW-1:0]      fill_m1;
  logic [CW-1:0]      ptr;
  logic [AW-1:0]      cmp_idx;
  logic               cmp_valid;
  logic [AW-1:0]      pend_idx;
  logic               pend_valid;
  logic [6:0]         mcount;
  logic signed [31:0] key;

  logic full, empty, out_free, capped, issue_ok, hit, stall, adv, out_load;
  logic is_push, is_read, is_search;
  logic rd_en;
  logic [AW-1:0] rd_addr;

  assign fill_m1   = fill - CW'(1);
  assign full      = (fill == CW'(DEPTH));
  assign empty     = (fill == '0);
  assign out_free  = !out_valid || m_tready;
  assign capped    = (mcount == MAX_RES);
  assign issue_ok  = (ptr < fill) && !capped;
  assign hit       = cmp_valid && (rd_data == key) && !capped;
  assign stall     = hit && pend_valid && !out_free;
  assign adv       = cmd.scan_en && !stall;

  assign is_push   = (kind == K_PUSH);
  assign is_read   = (kind == K_POP) || (kind == K_PEEK);
  assign is_search = (kind == K_SEARCH);

  assign out_load  = (cmd.accept && (is_push || empty)) || cmd.emit_read
                     || (adv && hit && pend_valid) || cmd.scan_finish;

  assign rd_en   = (cmd.accept && is_read && !empty) || (adv && issue_ok);
  assign rd_addr = cmd.accept ? fill_m1[AW-1:0] : ptr[AW-1:0];

  assign sts.empty     = empty;
  assign sts.out_free  = out_free;
  assign sts.scan_idle = capped || ((ptr == fill) && !cmp_valid);

  always_ff @(posedge clk) begin
    if (cmd.accept && is_push && !full) mem[fill[AW-1:0]] <= data_in;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      out_valid  <= 1'b0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      mcount     <= '0;
      ptr        <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      if (cmd.accept) begin
        if (is_push) begin
          out       <= '{status: full ? ST_FULL : ST_OK, data: '0, idx: '0,
                         count: '0, last: 1'b1};
          if (!full) fill <= fill + CW'(1);
        end else if (empty) begin
          out       <= '{status: ST_EMPTY, data: '0, idx: '0, count: '0, last: 1'b1};
        end else if (is_search) begin
          key        <= data_in;
          ptr        <= '0;
          cmp_valid  <= 1'b0;
          pend_valid <= 1'b0;
          mcount     <= '0;
        end else if (kind == K_POP) begin
          fill <= fill_m1;
        end
      end

      if (cmd.emit_read) begin
        out       <= '{status: ST_OK, data: rd_data, idx: '0, count: '0, last: 1'b1};
      end

      if (adv) begin
        cmp_valid <= issue_ok;
        if (issue_ok) begin
          cmp_idx <= ptr[AW-1:0];
          ptr     <= ptr + CW'(1);
        end
        if (hit) begin
          // older match is not the final one: release it
          if (pend_valid) begin
            out       <= '{status: ST_OK, data: '0, idx: 6'(pend_idx), count: mcount,
                           last: 1'b0};
          end
          pend_valid <= 1'b1;
          pend_idx   <= cmp_idx;
          mcount     <= mcount + 7'd1;
        end
      end

      if (cmd.scan_finish) begin
        if (pend_valid) begin
          out <= '{status: ST_OK, data: '0, idx: 6'(pend_idx), count: mcount, last: 1'b1};
        end else begin
          out <= '{status: ST_NOTFOUND, data: '0, idx: '0, count: '0, last: 1'b1};
        end
      end
    end
  end

endmodule

// ----- hdl/lifo_stack_with_search.sv -----
// LIFO stack of signed 32-bit words, DEPTH deep, with push, pop, peek and a
// linear search from the bottom up. A push result is registered on accept;
// pop and peek go through the registered read of the stack memory first.
// A search walks the single read port one entry per cycle unless output
// backpressure stalls it; input is held off until its final result is
// written. Each match gives one result with its index and running count
// (at most 64); the last carries tlast. No clearing pass after reset.
module lifo_stack_with_search
  import lstk_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_in
  input  logic [1:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // data_out, match_index, match_count, 3'b0
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast    // last
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  lstk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .kind     (s_tuser),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  lstk_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .kind      (s_tuser),
    .data_in   (s_tdata),
    .m_tready  (m_tready),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out       (res)
  );

  assign m_tdata = {3'b000, res.count, res.idx, res.data};
  assign m_tuser = res.status;
  assign m_tlast = res.last;

endmodule

// ----- hdl/lstk_chk.sv -----
module lstk_chk
  import lstk_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input changed while waiting");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tlast && (m_tdata == 48'd0))
    else $error("error result not final or not zero");

  a_mid_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> (m_tuser == ST_OK) && (m_tdata[44:38] != 7'd0)
      && (m_tdata[31:0] == 32'd0))
    else $error("non-final result is not a search match");

  a_no_take_mid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |-> !s_tready)
    else $error("input taken during search results");

endmodule

bind lifo_stack_with_search lstk_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
